// ===== sv/tcgr_pkg.sv =====
// Shared constants and types of the text console glyph renderer.
package tcgr_pkg;

    // Command codes carried in the input beat's tuser.
    localparam logic [1:0] CMD_PRINT  = 2'd0;
    localparam logic [1:0] CMD_FONT   = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;

    // Control characters.
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // Geometry of one text cell and one glyph.
    localparam int CELL_PIXELS  = 16;
    localparam int CELL_SHIFT   = $clog2(CELL_PIXELS);
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_ROW_W  = $clog2(GLYPH_ROWS);
    localparam int STEP_W       = 5;
    localparam int CLEAR_SLOTS  = 3;

    // Cursor coordinates are six bits wide and saturate at the top value.
    localparam logic [5:0] COORD_MAX = 6'd63;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_TOP    = 3'd2,
        REG_BOTTOM = 3'd3,
        REG_FG     = 3'd4,
        REG_BG     = 3'd5
    } cfg_reg_t;

    // Reset values of the registers.
    localparam logic [5:0]  RST_LEFT   = 6'd0;
    localparam logic [5:0]  RST_RIGHT  = 6'd60;
    localparam logic [5:0]  RST_TOP    = 6'd0;
    localparam logic [5:0]  RST_BOTTOM = 6'd34;
    localparam logic [31:0] RST_FG     = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_BG     = 32'h0000_0000;

endpackage

// ===== sv/tcgr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read and a write of the same entry in one cycle return the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/text_console_glyph_renderer_unit.sv =====
// Top level of the text console glyph renderer: cursor, margins, font store and sequencer.
//
// Usage: the input stream carries one command per beat, selected by s_tuser:
// print a character, load one font byte, or set the cursor. Font loads and
// cursor sets take effect in the cycle they are accepted and produce no beat.
// A print first applies the wrap checks, then emits clear-line commands
// (m_tuser = 1) and, for a printable code, sixteen glyph row beats
// (m_tuser = 0) carrying doubled pixel masks. m_tlast marks the final beat
// caused by one input beat. Prints that cause nothing emit nothing.
// The first result beat is registered in the output register after the
// sequencer state has been loaded from its input beat and a step issued.
// Throughput: one result beat per cycle while m_tready is high, so a
// printable character gives sixteen beats plus one per clear command, up to
// 18 beats; the sequencer issues one font store read per glyph row. The next input
// beat is taken in the cycle the last result of the current one is issued.
// Reset (aresetn low, synchronous) restores the margins and colors, homes the
// cursor and drops any beats in flight; the font store keeps its contents and
// is undefined until loaded. When m_tready is low the output register holds
// its beat, the sequencer waits and s_tready falls once work is pending.
module text_console_glyph_renderer_unit #(
    parameter int GLYPH_COUNT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: char_code[7:0], font_addr[17:8], font_byte[25:18],
    // cursor_col[31:26], cursor_row[37:32], zero padding[39:38].
    input  logic [39:0] s_tdata,
    // From bit 0: cmd[1:0].
    input  logic [1:0]  s_tuser,

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: pixel_x[9:0], pixel_y[19:10], text_line[25:20],
    // pixel_mask[41:26], zero padding[47:42].
    output logic [47:0] m_tdata,
    // From bit 0: kind[0].
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam int FONT_DEPTH = GLYPH_COUNT * tcgr_pkg::GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int ROW_IDX_W  = tcgr_pkg::CELL_SHIFT;

    // Saturating increment of a cursor coordinate.
    function automatic logic [5:0] inc6(input logic [5:0] v);
        inc6 = (v == tcgr_pkg::COORD_MAX) ? tcgr_pkg::COORD_MAX : v + 6'd1;
    endfunction

    // Each font bit becomes two adjacent mask bits, most significant first.
    function automatic logic [15:0] dbl(input logic [7:0] b);
        logic [15:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            m[2*j]   = b[j];
            m[2*j+1] = b[j];
        end
        dbl = m;
    endfunction

    // ---------------------------------------------------------------
    // Input field unpacking.
    // ---------------------------------------------------------------
    logic [1:0] in_cmd;
    logic [7:0] in_char;
    logic [9:0] in_font_addr;
    logic [7:0] in_font_byte;
    logic [5:0] in_col;
    logic [5:0] in_row;

    assign in_cmd       = s_tuser;
    assign in_char      = s_tdata[7:0];
    assign in_font_addr = s_tdata[17:8];
    assign in_font_byte = s_tdata[25:18];
    assign in_col       = s_tdata[31:26];
    assign in_row       = s_tdata[37:32];

    // ---------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------
    logic [5:0]  left_reg, right_reg, top_reg, bottom_reg;
    logic [31:0] fg_reg, bg_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= tcgr_pkg::RST_LEFT;
            right_reg  <= tcgr_pkg::RST_RIGHT;
            top_reg    <= tcgr_pkg::RST_TOP;
            bottom_reg <= tcgr_pkg::RST_BOTTOM;
            fg_reg     <= tcgr_pkg::RST_FG;
            bg_reg     <= tcgr_pkg::RST_BG;
        end else if (cfg_wr) begin
            unique case (tcgr_pkg::cfg_reg_t'(paddr[4:2]))
                tcgr_pkg::REG_LEFT:   left_reg   <= pwdata[5:0];
                tcgr_pkg::REG_RIGHT:  right_reg  <= pwdata[5:0];
                tcgr_pkg::REG_TOP:    top_reg    <= pwdata[5:0];
                tcgr_pkg::REG_BOTTOM: bottom_reg <= pwdata[5:0];
                tcgr_pkg::REG_FG:     fg_reg     <= pwdata;
                tcgr_pkg::REG_BG:     bg_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (tcgr_pkg::cfg_reg_t'(paddr[4:2]))
            tcgr_pkg::REG_LEFT:   prdata = {26'd0, left_reg};
            tcgr_pkg::REG_RIGHT:  prdata = {26'd0, right_reg};
            tcgr_pkg::REG_TOP:    prdata = {26'd0, top_reg};
            tcgr_pkg::REG_BOTTOM: prdata = {26'd0, bottom_reg};
            tcgr_pkg::REG_FG:     prdata = fg_reg;
            tcgr_pkg::REG_BG:     prdata = bg_reg;
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer and output register state.
    // ---------------------------------------------------------------
    logic [5:0]                  col_reg, row_reg;
    logic                        busy_reg;
    logic [5:0]                  line_reg [tcgr_pkg::CLEAR_SLOTS];
    logic [1:0]                  clr_cnt_reg;
    logic                        glyph_reg;
    logic [5:0]                  gcol_reg, grow_reg;
    logic [6:0]                  gchar_reg;
    logic [tcgr_pkg::STEP_W-1:0] step_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [9:0]  out_px_reg, out_py_reg;
    logic [5:0]  out_line_reg;
    logic        out_last_reg;

    logic s_fire;
    logic adv;
    logic step_last;

    // A step is issued when the output register is empty or being drained.
    assign adv    = busy_reg && (!out_valid_reg || m_tready);
    assign s_fire = s_tvalid && s_tready;
    // The next item enters while the final step of the current one issues.
    assign s_tready = !busy_reg || (adv && step_last);

    // ---------------------------------------------------------------
    // Print decode: wrap checks and the list of lines to clear.
    // ---------------------------------------------------------------
    logic [5:0] p_col, p_row;
    logic [5:0] p_line [tcgr_pkg::CLEAR_SLOTS];
    logic [1:0] p_cnt;
    logic       p_glyph;
    logic [5:0] p_gcol, p_grow;

    always_comb begin
        p_col   = col_reg;
        p_row   = row_reg;
        p_cnt   = 2'd0;
        p_glyph = 1'b0;
        for (int k = 0; k < tcgr_pkg::CLEAR_SLOTS; k++) begin
            p_line[k] = '0;
        end
        if (p_col > right_reg) begin
            p_row         = inc6(p_row);
            p_col         = left_reg;
            p_line[p_cnt] = p_row;
            p_cnt         = p_cnt + 2'd1;
        end
        if (p_row > bottom_reg) begin
            p_row         = top_reg;
            p_line[p_cnt] = p_row;
            p_cnt         = p_cnt + 2'd1;
        end
        p_gcol = p_col;
        p_grow = p_row;
        if (in_char == tcgr_pkg::CHAR_LF) begin
            p_col         = left_reg;
            p_row         = inc6(p_row);
            p_line[p_cnt] = p_row;
            p_cnt         = p_cnt + 2'd1;
        end else if (in_char == tcgr_pkg::CHAR_CR) begin
            p_col = left_reg;
        end else if (!in_char[7]) begin
            p_glyph = 1'b1;
            p_col   = inc6(p_col);
        end
    end

    // Cursor set, clamped; the high margin wins when the margins cross.
    logic [5:0] c_col, c_row;

    always_comb begin
        c_col = in_col;
        c_row = in_row;
        if (c_col < left_reg) begin
            c_col = left_reg;
        end
        if (c_col > right_reg) begin
            c_col = right_reg;
        end
        if (c_row < top_reg) begin
            c_row = top_reg;
        end
        if (c_row > bottom_reg) begin
            c_row = bottom_reg;
        end
    end

    // ---------------------------------------------------------------
    // Step decode: clear commands first, then the sixteen glyph rows.
    // ---------------------------------------------------------------
    logic [tcgr_pkg::STEP_W-1:0] step_total;
    logic                        step_is_clear;
    logic [tcgr_pkg::STEP_W-1:0] step_row_full;
    logic [ROW_IDX_W-1:0]        step_row;

    assign step_total    = tcgr_pkg::STEP_W'(clr_cnt_reg)
                         + (glyph_reg ? tcgr_pkg::STEP_W'(tcgr_pkg::CELL_PIXELS) : '0);
    assign step_last     = (step_reg == step_total - tcgr_pkg::STEP_W'(1));
    assign step_is_clear = (step_reg < tcgr_pkg::STEP_W'(clr_cnt_reg));
    assign step_row_full = step_reg - tcgr_pkg::STEP_W'(clr_cnt_reg);
    assign step_row      = step_row_full[ROW_IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            busy_reg <= 1'b0;
        end else if (s_fire && (in_cmd == tcgr_pkg::CMD_PRINT)) begin
            // A new print restarts the sequencer, even as the last step
            // of the previous one issues.
            col_reg     <= p_col;
            row_reg     <= p_row;
            line_reg    <= p_line;
            clr_cnt_reg <= p_cnt;
            glyph_reg   <= p_glyph;
            gcol_reg    <= p_gcol;
            grow_reg    <= p_grow;
            gchar_reg   <= in_char[6:0];
            step_reg    <= '0;
            busy_reg    <= p_glyph || (p_cnt != 2'd0);
        end else begin
            if (adv) begin
                step_reg <= step_reg + tcgr_pkg::STEP_W'(1);
                if (step_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_fire && (in_cmd == tcgr_pkg::CMD_CURSOR)) begin
                col_reg <= c_col;
                row_reg <= c_row;
            end
        end
    end

    // ---------------------------------------------------------------
    // Font store: written by font loads, read once per glyph row step.
    // ---------------------------------------------------------------
    logic               font_we;
    logic [FONT_AW-1:0] font_waddr, font_raddr;
    logic [7:0]         font_rdata;

    assign font_we    = s_fire && (in_cmd == tcgr_pkg::CMD_FONT)
                      && (32'(in_font_addr) < FONT_DEPTH);
    assign font_waddr = FONT_AW'(in_font_addr);
    assign font_raddr = FONT_AW'({gchar_reg, step_row[ROW_IDX_W-1 -: tcgr_pkg::GLYPH_ROW_W]});

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .aclk  (aclk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (in_font_byte),
        .re    (adv && !step_is_clear),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    // ---------------------------------------------------------------
    // Output register. The font read data holds while a beat is stalled,
    // since the store is read only when a new step is issued.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
            out_last_reg  <= step_last;
            if (step_is_clear) begin
                out_kind_reg <= 1'b1;
                out_px_reg   <= '0;
                out_py_reg   <= '0;
                out_line_reg <= line_reg[step_reg[1:0]];
            end else begin
                out_kind_reg <= 1'b0;
                out_px_reg   <= {gcol_reg, {tcgr_pkg::CELL_SHIFT{1'b0}}};
                out_py_reg   <= {grow_reg, step_row};
                out_line_reg <= '0;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [15:0] out_mask;

    assign out_mask = out_kind_reg ? 16'd0 : dbl(font_rdata);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_mask, out_line_reg, out_py_reg, out_px_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
